>>> sv/swt_pkg.sv
// ----------------------------------------------------------------------------
// Skeleton world transform package
// Shared constants, codes and types for the skeleton world transform unit.
// ----------------------------------------------------------------------------
package swt_pkg;

	localparam int MAX_BONES  = 1024;
	localparam int ADDR_W     = $clog2(MAX_BONES);
	localparam int CNT_W      = $clog2(MAX_BONES + 1);
	localparam int BONE_W     = 10;
	localparam int POS_W      = 32;
	localparam int QC_W       = 16;
	localparam int ENTRY_W    = 3 * POS_W + 4 * QC_W;

	localparam logic [15:0] ROOT_MARK = 16'hFFFF;

	typedef logic [1:0] err_t;
	localparam err_t ERR_OK    = 2'd0;
	localparam err_t ERR_ORDER = 2'd1;
	localparam err_t ERR_FULL  = 2'd2;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic rd;
		logic step1;
		logic step2;
		logic commit;
	} swt_cmd_t;

endpackage

>>> sv/swt_in_if.sv
// ----------------------------------------------------------------------------
// Bone input channel
// Valid/ready channel carrying one bone description per transaction.
// ----------------------------------------------------------------------------
interface swt_in_if import swt_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic                    first_bone;
	logic [15:0]             parent_index;
	logic signed [POS_W-1:0] local_x;
	logic signed [POS_W-1:0] local_y;
	logic signed [POS_W-1:0] local_z;
	logic signed [QC_W-1:0]  rot_x;
	logic signed [QC_W-1:0]  rot_y;
	logic signed [QC_W-1:0]  rot_z;
	logic signed [QC_W-1:0]  rot_w;

	modport source (output valid, first_bone, parent_index, local_x, local_y, local_z,
		rot_x, rot_y, rot_z, rot_w, input ready);
	modport sink (input valid, first_bone, parent_index, local_x, local_y, local_z,
		rot_x, rot_y, rot_z, rot_w, output ready);
endinterface

>>> sv/swt_out_if.sv
// ----------------------------------------------------------------------------
// World position output channel
// Valid/ready channel carrying one world position per transaction.
// ----------------------------------------------------------------------------
interface swt_out_if import swt_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic [BONE_W-1:0]       bone_number;
	logic signed [POS_W-1:0] world_x;
	logic signed [POS_W-1:0] world_y;
	logic signed [POS_W-1:0] world_z;
	err_t                    error_code;

	modport source (output valid, bone_number, world_x, world_y, world_z, error_code,
		input ready);
	modport sink (input valid, bone_number, world_x, world_y, world_z, error_code,
		output ready);
endinterface

>>> sv/swt_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module swt_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> sv/swt_ctrl.sv
// ----------------------------------------------------------------------------
// Skeleton world transform controller
// Sequences one bone through read, two arithmetic steps and commit.
// ----------------------------------------------------------------------------
module swt_ctrl import swt_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	output swt_cmd_t cmd
);

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_READ = 5'b00010,
		ST_MUL1 = 5'b00100,
		ST_MUL2 = 5'b01000,
		ST_DONE = 5'b10000
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   slot_free;

	assign slot_free = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd        = '0;
		cmd.load   = (state_q == ST_IDLE) && in_valid;
		cmd.rd     = (state_q == ST_READ);
		cmd.step1  = (state_q == ST_MUL1);
		cmd.step2  = (state_q == ST_MUL2);
		cmd.commit = (state_q == ST_DONE) && slot_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_READ;
					end
				end
				ST_READ: state_q <= ST_MUL1;
				ST_MUL1: state_q <= ST_MUL2;
				ST_MUL2: state_q <= ST_DONE;
				ST_DONE: begin
					if (slot_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_accept_reaches_done: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |-> ##4 (state_q == ST_DONE))
		else $error("accepted bone did not reach the commit state in time");

	a_commit_shows_result: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> out_valid)
		else $error("commit did not present a result");

	a_wait_holds_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && !slot_free) |=> (state_q == ST_DONE))
		else $error("left the commit state while the output was occupied");

endmodule

>>> sv/swt_dp.sv
// ----------------------------------------------------------------------------
// Skeleton world transform datapath
// Bone counter, world transform store and the fixed-point rotation arithmetic.
// ----------------------------------------------------------------------------
module swt_dp import swt_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  swt_cmd_t                cmd,
	input  logic                    first_bone,
	input  logic [15:0]             parent_index,
	input  logic signed [POS_W-1:0] local_x,
	input  logic signed [POS_W-1:0] local_y,
	input  logic signed [POS_W-1:0] local_z,
	input  logic signed [QC_W-1:0]  rot_x,
	input  logic signed [QC_W-1:0]  rot_y,
	input  logic signed [QC_W-1:0]  rot_z,
	input  logic signed [QC_W-1:0]  rot_w,
	output logic [BONE_W-1:0]       bone_number,
	output logic signed [POS_W-1:0] world_x,
	output logic signed [POS_W-1:0] world_y,
	output logic signed [POS_W-1:0] world_z,
	output err_t                    error_code
);

	// Truncating divisions by 2^14, rounding toward zero; q_div_sat also saturates to 16 bits.
	function automatic logic signed [35:0] t_div(input logic signed [49:0] v);
		logic signed [49:0] a;
		a = v + (v[49] ? 50'sd16383 : 50'sd0);
		return a[49:14];
	endfunction

	function automatic logic signed [39:0] p_div(input logic signed [53:0] v);
		logic signed [53:0] a;
		a = v + (v[53] ? 54'sd16383 : 54'sd0);
		return a[53:14];
	endfunction

	function automatic logic signed [15:0] q_div_sat(input logic signed [33:0] v);
		logic signed [33:0] a;
		logic signed [19:0] s;
		a = v + (v[33] ? 34'sd16383 : 34'sd0);
		s = a[33:14];
		if (s > 20'sd32767) return 16'sh7FFF;
		if (s < -20'sd32768) return 16'sh8000;
		return s[15:0];
	endfunction

	logic [CNT_W-1:0]        cnt_q;
	logic [CNT_W-1:0]        cnt_eff;
	logic                    full_q;
	logic                    use_parent_q;
	logic                    order_bad_q;
	logic [CNT_W-1:0]        idx_q;
	logic [ADDR_W-1:0]       parent_q;
	logic signed [POS_W-1:0] lv_q [3];
	logic signed [QC_W-1:0]  lq_q [4];

	logic [ENTRY_W-1:0]      rdata;
	logic [ENTRY_W-1:0]      wdata;
	logic                    ram_we;
	logic signed [POS_W-1:0] pp [3];
	logic signed [QC_W-1:0]  pq [4];

	logic signed [35:0]      t_s1 [3];
	logic signed [QC_W-1:0]  wq_s1 [4];
	logic signed [POS_W-1:0] p_s2 [3];

	logic signed [47:0]      m1 [6];
	logic signed [49:0]      d1 [3];
	logic signed [35:0]      t_n [3];
	logic signed [31:0]      mq [16];
	logic signed [QC_W-1:0]  wq_n [4];
	logic signed [51:0]      m2 [9];
	logic signed [53:0]      s2 [3];
	logic signed [39:0]      p_n [3];
	logic signed [POS_W-1:0] w_n [3];
	logic signed [QC_W-1:0]  rq_n [4];
	logic                    root_in;
	logic                    full_in;

	assign cnt_eff = first_bone ? '0 : cnt_q;
	assign root_in = (parent_index == ROOT_MARK);
	assign full_in = (32'(cnt_eff) >= 32'(MAX_BONES));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.load) begin
			cnt_q <= full_in ? cnt_eff : cnt_eff + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			full_q       <= full_in;
			idx_q        <= cnt_eff;
			order_bad_q  <= !root_in && (32'(parent_index) >= 32'(cnt_eff));
			use_parent_q <= !root_in && (32'(parent_index) < 32'(cnt_eff)) && !full_in;
			parent_q     <= parent_index[ADDR_W-1:0];
			lv_q[0]      <= local_x;
			lv_q[1]      <= local_y;
			lv_q[2]      <= local_z;
			lq_q[0]      <= rot_x;
			lq_q[1]      <= rot_y;
			lq_q[2]      <= rot_z;
			lq_q[3]      <= rot_w;
		end
	end

	// Store entry: x, y, z position then the rotation with x in the low half-word.
	swt_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_BONES)) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (idx_q[ADDR_W-1:0]),
		.wdata (wdata),
		.re    (cmd.rd),
		.raddr (parent_q),
		.rdata (rdata)
	);

	always_comb begin
		pp[0] = rdata[31:0];
		pp[1] = rdata[63:32];
		pp[2] = rdata[95:64];
		for (int i = 0; i < 4; i++) begin
			pq[i] = rdata[96 + 16*i +: 16];
		end
	end

	// First step: the cross product for t and the quaternion product.
	always_comb begin
		m1[0] = pq[1] * lv_q[2];
		m1[1] = pq[2] * lv_q[1];
		m1[2] = pq[2] * lv_q[0];
		m1[3] = pq[0] * lv_q[2];
		m1[4] = pq[0] * lv_q[1];
		m1[5] = pq[1] * lv_q[0];
		for (int i = 0; i < 3; i++) begin
			d1[i]  = (50'(m1[2*i]) - 50'(m1[2*i+1])) <<< 1;
			t_n[i] = t_div(d1[i]);
		end
		for (int a = 0; a < 4; a++) begin
			for (int b = 0; b < 4; b++) begin
				mq[4*a+b] = pq[a] * lq_q[b];
			end
		end
		wq_n[0] = q_div_sat(34'(mq[12]) + 34'(mq[3]) + 34'(mq[6]) - 34'(mq[9]));
		wq_n[1] = q_div_sat(34'(mq[13]) - 34'(mq[2]) + 34'(mq[7]) + 34'(mq[8]));
		wq_n[2] = q_div_sat(34'(mq[14]) + 34'(mq[1]) - 34'(mq[4]) + 34'(mq[11]));
		wq_n[3] = q_div_sat(34'(mq[15]) - 34'(mq[0]) - 34'(mq[5]) - 34'(mq[10]));
	end

	always_ff @(posedge clk) begin
		if (cmd.step1) begin
			t_s1  <= t_n;
			wq_s1 <= wq_n;
		end
	end

	// Second step: p = v + (w*t + q.xyz x t) / 2^14.
	always_comb begin
		m2[0] = pq[3] * t_s1[0];
		m2[1] = pq[1] * t_s1[2];
		m2[2] = pq[2] * t_s1[1];
		m2[3] = pq[3] * t_s1[1];
		m2[4] = pq[2] * t_s1[0];
		m2[5] = pq[0] * t_s1[2];
		m2[6] = pq[3] * t_s1[2];
		m2[7] = pq[0] * t_s1[1];
		m2[8] = pq[1] * t_s1[0];
		for (int i = 0; i < 3; i++) begin
			s2[i]  = 54'(m2[3*i]) + 54'(m2[3*i+1]) - 54'(m2[3*i+2]);
			p_n[i] = p_div(s2[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.step2) begin
			for (int i = 0; i < 3; i++) begin
				p_s2[i] <= lv_q[i] + p_n[i][31:0];
			end
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			w_n[i] = use_parent_q ? pp[i] + p_s2[i] : lv_q[i];
		end
		for (int i = 0; i < 4; i++) begin
			rq_n[i] = use_parent_q ? wq_s1[i] : lq_q[i];
		end
		wdata  = {rq_n[3], rq_n[2], rq_n[1], rq_n[0], w_n[2], w_n[1], w_n[0]};
		ram_we = cmd.commit && !full_q;
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			bone_number <= full_q ? '0 : BONE_W'(idx_q);
			world_x     <= w_n[0];
			world_y     <= w_n[1];
			world_z     <= w_n[2];
			error_code  <= full_q ? ERR_FULL : (order_bad_q ? ERR_ORDER : ERR_OK);
		end
	end

	a_cnt_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		32'(cnt_q) <= 32'(MAX_BONES))
		else $error("bone counter ran past capacity");

endmodule

>>> sv/skeleton_world_transform_unit.sv
// ----------------------------------------------------------------------------
// Skeleton world transform unit
// Forward kinematics for a quaternion skeleton in fixed point.
// ----------------------------------------------------------------------------
//
//   Channel    Direction  Contents per transaction
//   bone_in    sink       start flag, parent index, local position, rotation
//   pos_out    source     bone number, world position, error code
//
// A bone is latched on acceptance, then the parent's entry is read from the
// single-port-read store, the two dependent multiply steps follow, and last
// the entry is committed and the output register loaded; only then is the
// next bone accepted. Reset clears the bone counter and control; the store
// is not cleared. A stalled output holds the block in its commit state, but
// a new bone is taken while a finished result still waits in the output
// register.
//
module skeleton_world_transform_unit import swt_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	swt_in_if.sink  bone_in,
	swt_out_if.source pos_out
);

	swt_cmd_t cmd;

	// The controller owns the handshakes and the step sequence.
	swt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (bone_in.valid),
		.in_ready  (bone_in.ready),
		.out_valid (pos_out.valid),
		.out_ready (pos_out.ready),
		.cmd       (cmd)
	);

	// The datapath holds the counter, the store and the arithmetic.
	swt_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.first_bone   (bone_in.first_bone),
		.parent_index (bone_in.parent_index),
		.local_x      (bone_in.local_x),
		.local_y      (bone_in.local_y),
		.local_z      (bone_in.local_z),
		.rot_x        (bone_in.rot_x),
		.rot_y        (bone_in.rot_y),
		.rot_z        (bone_in.rot_z),
		.rot_w        (bone_in.rot_w),
		.bone_number  (pos_out.bone_number),
		.world_x      (pos_out.world_x),
		.world_y      (pos_out.world_y),
		.world_z      (pos_out.world_z),
		.error_code   (pos_out.error_code)
	);

endmodule

>>> tb/sv/skeleton_world_transform_unit_test.sv
// ----------------------------------------------------------------------------
// Skeleton world transform unit testbench
// Drives skeletons of bones through the unit and checks every world position
// and error code against a bit-exact fixed-point forward kinematics predictor.
// ----------------------------------------------------------------------------
module skeleton_world_transform_unit_test;
	import swt_pkg::*;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int RANDOM_BONES = 1000;
	localparam int LONG_SKEL_AT = 60;
	localparam int PAUSE_AT     = 250;
	localparam int HOLD_AT      = 700;
	localparam int HOLD_CYCLES  = 300;
	localparam int QUIET_TAIL   = 150;
	localparam int DRAIN_CYCLES = 12;
	localparam longint QONE     = 16384;

	// One bone as offered on the input channel.
	typedef struct {
		logic              first_bone;
		logic [15:0]       parent_index;
		logic signed [31:0] lx, ly, lz;
		logic signed [15:0] qx, qy, qz, qw;
	} bone_t;

	// One world position as it should leave the unit.
	typedef struct {
		logic [BONE_W-1:0]  bone_number;
		logic signed [31:0] wx, wy, wz;
		err_t               err;
	} world_pos_t;

	// A row of the directed table: a bone and, where it is obvious, its result.
	typedef struct {
		bone_t      bone;
		bit         typed;
		world_pos_t result;
	} row_t;

	logic clk;
	logic arst_n;

	swt_in_if  bone_in ();
	swt_out_if pos_out ();

	skeleton_world_transform_unit dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.bone_in (bone_in),
		.pos_out (pos_out)
	);

	// Predictor state: the bone count of the current skeleton and, per bone,
	// its world position and world rotation as the unit stores them.
	int                 bone_count;
	logic signed [31:0] world_px [MAX_BONES];
	logic signed [31:0] world_py [MAX_BONES];
	logic signed [31:0] world_pz [MAX_BONES];
	logic signed [15:0] world_q  [MAX_BONES][4];

	world_pos_t pending_pos[$];
	int         mismatches;
	int         bones_sent;
	int         results_seen;
	int         order_errors_seen;
	int         full_errors_seen;
	int         cycles;
	bit         quiet;
	bit         hold_request;
	row_t       directed[$];

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
			$display("[skeleton_world_transform_unit] ERROR");
			$finish;
		end
	end

	// Quaternion component: the product sum is truncated towards zero and then
	// saturated to the signed 16-bit range.
	function automatic logic signed [15:0] quat_component(longint sum);
		longint s;
		s = sum / QONE;
		if (s > 32767)
			s = 32767;
		else if (s < -32768)
			s = -32768;
		return s[15:0];
	endfunction

	// Works out the world position of one accepted bone and updates the
	// predictor's copy of the stores exactly as the unit updates its own.
	function automatic world_pos_t forward_kinematics(bone_t b);
		world_pos_t r;
		longint     v[3], q[4], lq[4], t[3], p[3];
		int         par;
		int         idx;
		logic signed [15:0] nq[4];

		if (b.first_bone)
			bone_count = 0;
		v[0] = b.lx; v[1] = b.ly; v[2] = b.lz;
		lq[0] = b.qx; lq[1] = b.qy; lq[2] = b.qz; lq[3] = b.qw;
		nq[0] = b.qx; nq[1] = b.qy; nq[2] = b.qz; nq[3] = b.qw;
		r.wx = b.lx; r.wy = b.ly; r.wz = b.lz;
		r.err = ERR_OK;

		// A full skeleton stores nothing and reports the local position.
		if (bone_count >= MAX_BONES) begin
			r.bone_number = '0;
			r.err = ERR_FULL;
			return r;
		end

		idx = bone_count;
		par = b.parent_index;
		if (b.parent_index != ROOT_MARK) begin
			if (par >= idx) begin
				// The parent has not been seen yet: the bone is taken as a root.
				r.err = ERR_ORDER;
			end else begin
				for (int i = 0; i < 4; i++)
					q[i] = world_q[par][i];
				t[0] = (2 * (q[1] * v[2] - q[2] * v[1])) / QONE;
				t[1] = (2 * (q[2] * v[0] - q[0] * v[2])) / QONE;
				t[2] = (2 * (q[0] * v[1] - q[1] * v[0])) / QONE;
				p[0] = v[0] + (q[3] * t[0] + q[1] * t[2] - q[2] * t[1]) / QONE;
				p[1] = v[1] + (q[3] * t[1] + q[2] * t[0] - q[0] * t[2]) / QONE;
				p[2] = v[2] + (q[3] * t[2] + q[0] * t[1] - q[1] * t[0]) / QONE;
				r.wx = world_px[par] + p[0][31:0];
				r.wy = world_py[par] + p[1][31:0];
				r.wz = world_pz[par] + p[2][31:0];
				nq[0] = quat_component(q[3] * lq[0] + q[0] * lq[3] + q[1] * lq[2]
					- q[2] * lq[1]);
				nq[1] = quat_component(q[3] * lq[1] - q[0] * lq[2] + q[1] * lq[3]
					+ q[2] * lq[0]);
				nq[2] = quat_component(q[3] * lq[2] + q[0] * lq[1] - q[1] * lq[0]
					+ q[2] * lq[3]);
				nq[3] = quat_component(q[3] * lq[3] - q[0] * lq[0] - q[1] * lq[1]
					- q[2] * lq[2]);
			end
		end

		world_px[idx] = r.wx;
		world_py[idx] = r.wy;
		world_pz[idx] = r.wz;
		for (int i = 0; i < 4; i++)
			world_q[idx][i] = nq[i];
		bone_count = idx + 1;
		r.bone_number = idx[BONE_W-1:0];
		return r;
	endfunction

	function automatic row_t table_row(logic first, logic [15:0] parent,
		logic [31:0] x, logic [31:0] y, logic [31:0] z,
		logic [15:0] qx, logic [15:0] qy, logic [15:0] qz, logic [15:0] qw,
		bit typed, int bn, err_t err);
		row_t row;
		row.bone.first_bone = first;
		row.bone.parent_index = parent;
		row.bone.lx = x; row.bone.ly = y; row.bone.lz = z;
		row.bone.qx = qx; row.bone.qy = qy; row.bone.qz = qz; row.bone.qw = qw;
		row.typed = typed;
		// Rows with a typed result are roots or rejected bones, which report
		// their local position unchanged.
		row.result.bone_number = bn[BONE_W-1:0];
		row.result.wx = x; row.result.wy = y; row.result.wz = z;
		row.result.err = err;
		return row;
	endfunction

	// Appends one row to the end of the directed table.
	function automatic void add_row(row_t row);
		directed.insert(directed.size(), row);
	endfunction

	// Offers one bone, sometimes with a random idle burst first unless the run is in
	// its quiet tail, and records the expected result once the unit accepts it.
	task automatic offer_bone(bone_t b, bit typed, world_pos_t typed_result);
		world_pos_t predicted;
		int gap;
		if (!quiet && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 16);
			bone_in.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		bone_in.valid        <= 1'b1;
		bone_in.first_bone   <= b.first_bone;
		bone_in.parent_index <= b.parent_index;
		bone_in.local_x      <= b.lx;
		bone_in.local_y      <= b.ly;
		bone_in.local_z      <= b.lz;
		bone_in.rot_x        <= b.qx;
		bone_in.rot_y        <= b.qy;
		bone_in.rot_z        <= b.qz;
		bone_in.rot_w        <= b.qw;
		do
			@(posedge clk);
		while (!bone_in.ready);
		predicted = forward_kinematics(b);
		pending_pos.insert(pending_pos.size(), typed ? typed_result : predicted);
		bones_sent++;
		@(negedge clk);
	endtask

	function automatic logic [15:0] random_rot_part();
		// Mostly values in the range of a unit quaternion, sometimes anything.
		if ($urandom_range(0, 3) == 0)
			return $urandom_range(0, 65535);
		return $urandom_range(0, 32768) - 16384;
	endfunction

	function automatic logic [31:0] random_coord();
		case ($urandom_range(0, 3))
			0:       return $urandom;
			1:       return $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
			default: return $urandom_range(0, 32'h0400_0000) - 32'h0200_0000;
		endcase
	endfunction

	// Builds one random bone for the current skeleton. Most bones name a
	// parent already stored; the rest are roots, out-of-order parents or noise.
	function automatic bone_t random_bone(bit first);
		bone_t b;
		int    count;
		int    roll;
		count = first ? 0 : bone_count;
		b.first_bone = first;
		roll = $urandom_range(0, 99);
		if (count == 0 || (roll >= 75 && roll < 85))
			b.parent_index = ROOT_MARK;
		else if (roll < 75)
			b.parent_index = $urandom_range(0, (count > MAX_BONES ? MAX_BONES : count) - 1);
		else if (roll < 93)
			b.parent_index = $urandom_range(count, 65534);
		else
			b.parent_index = $urandom_range(0, 65535);
		if (roll >= 93 && $urandom_range(0, 1) == 0)
			b.first_bone = $urandom_range(0, 1);
		b.lx = random_coord();
		b.ly = random_coord();
		b.lz = random_coord();
		b.qx = random_rot_part();
		b.qy = random_rot_part();
		b.qz = random_rot_part();
		b.qw = random_rot_part();
		// A bone marked as a new skeleton must not name an unwritten parent
		// other than through the out-of-order check, which it always trips.
		return b;
	endfunction

	// Receiver: random stalls, one long hold-off on request, none at the end.
	initial begin
		int stall_left;
		int calm_left;
		bit held;
		stall_left = 0;
		calm_left = 0;
		held = 1'b0;
		pos_out.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_request && !held) begin
				// Long hold-off so the result register fills and input stalls.
				held = 1'b1;
				pos_out.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				pos_out.ready <= 1'b1;
			end else if (quiet || calm_left > 0) begin
				if (calm_left > 0)
					calm_left--;
				pos_out.ready <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				pos_out.ready <= 1'b0;
			end else if ($urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(1, 16) - 1;
				pos_out.ready <= 1'b0;
			end else begin
				if ($urandom_range(0, 60) == 0)
					calm_left = $urandom_range(20, 80);
				pos_out.ready <= 1'b1;
			end
		end
	end

	task automatic report_field(string name, longint expected, longint actual);
		$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, expected, actual);
		mismatches++;
	endtask

	// Every result transaction is compared with the oldest expectation.
	always @(posedge clk) begin
		world_pos_t want;
		if (arst_n && pos_out.valid && pos_out.ready) begin
			results_seen++;
			if (pos_out.error_code == ERR_ORDER)
				order_errors_seen++;
			if (pos_out.error_code == ERR_FULL)
				full_errors_seen++;
			if (pending_pos.size() == 0) begin
				$display("%0t: unexpected result for bone %0d", $time, pos_out.bone_number);
				mismatches++;
			end else begin
				want = pending_pos.pop_front();
				if (pos_out.bone_number !== want.bone_number)
					report_field("bone_number", want.bone_number, pos_out.bone_number);
				if (pos_out.world_x !== want.wx)
					report_field("world_x", want.wx, pos_out.world_x);
				if (pos_out.world_y !== want.wy)
					report_field("world_y", want.wy, pos_out.world_y);
				if (pos_out.world_z !== want.wz)
					report_field("world_z", want.wz, pos_out.world_z);
				if (pos_out.error_code !== want.err)
					report_field("error_code", want.err, pos_out.error_code);
			end
		end
	end

	initial begin
		bone_t b;
		int    skeleton_size;
		int    random_sent;
		bit    long_skel;
		bit    long_done;

		bone_count = 0;
		mismatches = 0;
		bones_sent = 0;
		results_seen = 0;
		order_errors_seen = 0;
		full_errors_seen = 0;
		quiet = 1'b0;
		hold_request = 1'b0;
		arst_n = 1'b0;
		bone_in.valid = 1'b0;
		bone_in.first_bone = 1'b0;
		bone_in.parent_index = '0;
		bone_in.local_x = '0;
		bone_in.local_y = '0;
		bone_in.local_z = '0;
		bone_in.rot_x = '0;
		bone_in.rot_y = '0;
		bone_in.rot_z = '0;
		bone_in.rot_w = '0;

		// Directed table. Roots and rejected bones carry their typed result,
		// children are left to the predictor.
		add_row(table_row(1, ROOT_MARK, 32'h0001_0000, 32'h0002_0000,
			32'h0003_0000, 0, 0, 0, 16384, 1, 0, ERR_OK));
		add_row(table_row(0, 0, 32'h0001_0000, 32'h0000_0000,
			32'hFFFF_0000, 0, 0, 0, 16384, 0, 0, ERR_OK));
		// Root at the extremes of position and rotation.
		add_row(table_row(0, ROOT_MARK, 32'h7FFF_FFFF, 32'h8000_0000,
			32'h0000_0000, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 1, 2, ERR_OK));
		// A child and a grandchild of the extreme root: rotation products saturate, sums wrap.
		add_row(table_row(0, 2, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			32'h8000_0000, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 0, 0, ERR_OK));
		add_row(table_row(0, 3, 32'h8000_0000, 32'hFFFF_FFFF,
			32'h7FFF_FFFF, 16'hFFFF, 16'h0000, 16'h7FFF, 16'h8000, 0, 0, ERR_OK));
		// Parent equal to the bone's own number, then the highest non-root index.
		add_row(table_row(0, 5, 32'h0000_1234, 32'hFFFF_EDCB,
			32'h0000_0001, 0, 0, 0, 16384, 1, 5, ERR_ORDER));
		add_row(table_row(0, 16'hFFFE, 32'h8000_0000, 32'h7FFF_FFFF,
			32'h0000_0000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 1, 6, ERR_ORDER));
		// New skeleton whose first bone names a parent: nothing is stored yet.
		add_row(table_row(1, 0, 32'h0005_0000, 32'h0006_0000,
			32'h0007_0000, 0, 0, 0, 16384, 1, 0, ERR_ORDER));
		// A fresh skeleton with a quarter turn about z.
		add_row(table_row(1, ROOT_MARK, 32'h0000_0000, 32'h0000_0000,
			32'h0000_0000, 0, 0, 11585, 11585, 1, 0, ERR_OK));
		add_row(table_row(0, 0, 32'h0001_0000, 32'h0000_0000,
			32'h0000_0000, 0, 0, 11585, 11585, 0, 0, ERR_OK));
		add_row(table_row(0, 1, 32'h0001_0000, 32'h0002_0000,
			32'hFFFE_0000, 16'h2000, 16'hE000, 16'h2000, 16'h2000, 0, 0, ERR_OK));
		add_row(table_row(0, ROOT_MARK, 32'hFFFF_FFFF, 32'h0000_0001,
			32'h8000_0000, 16'h7FFF, 16'h0000, 16'h0000, 16'h0000, 1, 3, ERR_OK));
		add_row(table_row(0, 3, 32'h0003_8000, 32'hFFFC_8000,
			32'h0000_4000, 16'h1000, 16'h2000, 16'h3000, 16'h0800, 0, 0, ERR_OK));
		add_row(table_row(0, 2, 32'h0000_0000, 32'h0000_0000,
			32'h0000_0000, 0, 0, 0, 0, 0, 0, ERR_OK));

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed[i])
			offer_bone(directed[i].bone, directed[i].typed, directed[i].result);

		// Random skeletons, mostly well formed. One skeleton is driven past its
		// capacity so the saturated counter and the full error are exercised;
		// none of its later bones restarts the numbering.
		random_sent = 0;
		long_done = 1'b0;
		while (random_sent < RANDOM_BONES) begin
			long_skel = !long_done && random_sent >= LONG_SKEL_AT;
			if (long_skel) begin
				skeleton_size = MAX_BONES + $urandom_range(3, 8);
				long_done = 1'b1;
			end else begin
				skeleton_size = $urandom_range(1, 40);
			end
			for (int n = 0; n < skeleton_size; n++) begin
				b = random_bone(n == 0);
				if (n == 0)
					b.first_bone = 1'b1;
				else if (long_skel)
					b.first_bone = 1'b0;
				if (random_sent == PAUSE_AT) begin
					// Sender holds back until every outstanding result is out.
					bone_in.valid <= 1'b0;
					wait (pending_pos.size() == 0);
					@(negedge clk);
				end
				if (random_sent == HOLD_AT)
					hold_request = 1'b1;
				if (RANDOM_BONES - random_sent <= QUIET_TAIL)
					quiet = 1'b1;
				offer_bone(b, 1'b0, '{default: '0});
				random_sent++;
			end
		end
		bone_in.valid <= 1'b0;

		wait (pending_pos.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Checked %0d bones in %0d results: %0d out-of-order parents, %0d over capacity.",
			bones_sent, results_seen, order_errors_seen, full_errors_seen);
		if (mismatches == 0 && pending_pos.size() == 0)
			$display("[skeleton_world_transform_unit] OK");
		else
			$display("[skeleton_world_transform_unit] ERROR");
		$finish;
	end

endmodule

>>> filelist.f
sv/swt_pkg.sv
sv/swt_in_if.sv
sv/swt_out_if.sv
sv/swt_ram.sv
sv/swt_ctrl.sv
sv/swt_dp.sv
sv/skeleton_world_transform_unit.sv
tb/sv/skeleton_world_transform_unit_test.sv
